// ===== sv/bounded_doubly_linked_list_macros.svh =====
// assertion macros shared by the list block
// used by files that carry concurrent checks; relies on clk and rst_n in scope
`ifndef BOUNDED_DOUBLY_LINKED_LIST_MACROS_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_MACROS_SVH

// same-cycle implication, quiet during reset
`define BDLL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define BDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bdll_pkg.sv =====
// shared types and constants of the bounded doubly linked list
// no dependencies
`default_nettype none

package bdll_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;

    typedef enum logic [2:0] {
        FN_INSERT    = 3'd0,
        FN_DEL_KEY   = 3'd1,
        FN_DEL_FIRST = 3'd2,
        FN_DEL_LAST  = 3'd3,
        FN_DUMP      = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE  = 3'd0,
        ST_FULL  = 3'd1,
        ST_NONE  = 3'd2,
        ST_ELEM  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS,
        S_INS2,
        S_DK,
        S_UL,
        S_DUMP,
        S_RESULT
    } state_t;

    typedef struct packed {
        func_t                    func;
        logic signed [KEY_W-1:0]  key;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [KEY_W-1:0]  out_key;
        logic                     last_of_run;
    } rsp_t;

endpackage

`default_nettype wire

// ===== sv/bdll_store.sv =====
// entry store: key, next link and prev link memories, one shared read port
// depends on bdll_pkg for the key width
`default_nettype none

module bdll_store #(
    parameter int CAPACITY = bdll_pkg::CAPACITY_DEF,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int LW = $clog2(CAPACITY + 1)
) (
    input  wire logic                             clk,
    input  wire logic                             rd_en,
    input  wire logic [IW-1:0]                    rd_addr,
    output logic signed [bdll_pkg::KEY_W-1:0]     rd_key,
    output logic [LW-1:0]                         rd_next,
    output logic [LW-1:0]                         rd_prev,
    input  wire logic                             key_we,
    input  wire logic [IW-1:0]                    key_wa,
    input  wire logic signed [bdll_pkg::KEY_W-1:0] key_wd,
    input  wire logic                             next_we,
    input  wire logic [IW-1:0]                    next_wa,
    input  wire logic [LW-1:0]                    next_wd,
    input  wire logic                             prev_we,
    input  wire logic [IW-1:0]                    prev_wa,
    input  wire logic [LW-1:0]                    prev_wd
);

    logic signed [bdll_pkg::KEY_W-1:0] key_mem  [CAPACITY];
    logic [LW-1:0]                     next_mem [CAPACITY];
    logic [LW-1:0]                     prev_mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (rd_en)
        begin
            rd_key  <= key_mem[rd_addr];
            rd_next <= next_mem[rd_addr];
            rd_prev <= prev_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bdll_free.sv =====
// free entry stack with its count; unwritten slots read as their reset order
// depends on bdll_pkg for defaults
`default_nettype none

module bdll_free #(
    parameter int CAPACITY = bdll_pkg::CAPACITY_DEF,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int LW = $clog2(CAPACITY + 1)
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop,
    input  wire logic           push,
    input  wire logic [IW-1:0]  push_data,
    output logic [LW-1:0]       count,
    output logic [IW-1:0]       pop_data
);

    logic [IW-1:0] stack_mem [CAPACITY];
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] low_reg, low_next;
    logic [IW-1:0] data_reg;
    logic [IW-1:0] pos_reg;
    logic          init_reg;
    logic [LW-1:0] top_pos;

    // slots below the lowest count ever reached still hold the reset order
    assign top_pos = count_reg - LW'(1);
    assign count   = count_reg;
    assign pop_data = init_reg ? (IW'(CAPACITY - 1) - pos_reg) : data_reg;

    always_comb
    begin
        count_next = count_reg;
        low_next   = low_reg;
        if (pop)
        begin
            count_next = top_pos;
            if (top_pos < low_reg)
            begin
                low_next = top_pos;
            end
        end
        else if (push && (count_reg < LW'(CAPACITY)))
        begin
            count_next = count_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= LW'(CAPACITY);
            low_reg   <= LW'(CAPACITY);
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= stack_mem[top_pos[IW-1:0]];
            pos_reg  <= top_pos[IW-1:0];
            init_reg <= (top_pos < low_reg);
        end
        else if (push && (count_reg < LW'(CAPACITY)))
        begin
            stack_mem[count_reg[IW-1:0]] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bounded_doubly_linked_list.sv =====
// top level of the bounded doubly linked list of signed keys
// depends on bdll_pkg, bdll_store, bdll_free and the assertion macro header
//
//  channel | handshake        | word   | meaning
//  --------+------------------+--------+-------------------------------------------
//  req     | req_valid/stall  | req_t  | one operation: func and key
//  rsp     | rsp_valid/stall  | rsp_t  | status, dumped key, last word of the run
//
// one operation at a time; req_stall is high while an operation is in flight
// insert writes the new entry, then the old head's back link if there is one;
// delete by key walks entries from the head and dump emits one word per entry,
// each list step waiting for the registered read of the entry memory
// reset clears state, head, tail, output valid and free count; memories need no clearing pass
// a stalled rsp holds the engine in place; one output register decouples the sides
`default_nettype none
`include "bounded_doubly_linked_list_macros.svh"

module bounded_doubly_linked_list #(
    parameter int CAPACITY = bdll_pkg::CAPACITY_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire bdll_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output bdll_pkg::rsp_t       rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    bdll_pkg::state_t  state_reg, state_next;
    bdll_pkg::req_t    req_reg;
    bdll_pkg::status_t res_reg, res_next;
    bdll_pkg::rsp_t    out_reg, emit_word;
    logic              out_valid_reg;
    logic [LW-1:0]     head_reg, head_next;
    logic [LW-1:0]     tail_reg, tail_next;
    logic [LW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     cnt_reg, cnt_next;

    // store ports
    logic                              rd_en;
    logic [IW-1:0]                     rd_addr;
    logic signed [bdll_pkg::KEY_W-1:0] rd_key;
    logic [LW-1:0]                     rd_next, rd_prev;
    logic                              key_we, next_we, prev_we;
    logic [IW-1:0]                     key_wa, next_wa, prev_wa;
    logic [LW-1:0]                     next_wd, prev_wd;

    // free stack ports
    logic          pop, push;
    logic [IW-1:0] push_data, pop_data;
    logic [LW-1:0] free_cnt;

    logic emit;
    logic slot_free;
    logic do_unlink;
    logic dump_last;

    bdll_store #(.CAPACITY(CAPACITY)) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_next (rd_next),
        .rd_prev (rd_prev),
        .key_we  (key_we),
        .key_wa  (key_wa),
        .key_wd  (req_reg.key),
        .next_we (next_we),
        .next_wa (next_wa),
        .next_wd (next_wd),
        .prev_we (prev_we),
        .prev_wa (prev_wa),
        .prev_wd (prev_wd)
    );

    bdll_free #(.CAPACITY(CAPACITY)) u_free (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .push      (push),
        .push_data (push_data),
        .count     (free_cnt),
        .pop_data  (pop_data)
    );

    // output slot can take a word when empty or being drained this cycle
    assign slot_free = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != bdll_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign dump_last = (rd_next >= NIL) || (cnt_reg == IW'(CAPACITY - 1));

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        rd_en      = 1'b0;
        rd_addr    = cur_reg[IW-1:0];
        key_we     = 1'b0;
        key_wa     = cur_reg[IW-1:0];
        next_we    = 1'b0;
        next_wa    = cur_reg[IW-1:0];
        next_wd    = NIL;
        prev_we    = 1'b0;
        prev_wa    = cur_reg[IW-1:0];
        prev_wd    = NIL;
        pop        = 1'b0;
        push       = 1'b0;
        push_data  = cur_reg[IW-1:0];
        emit       = 1'b0;
        emit_word  = '{status: bdll_pkg::ST_DONE, out_key: '0, last_of_run: 1'b1};
        do_unlink  = 1'b0;

        unique case (state_reg)
            bdll_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bdll_pkg::S_START;
                end
            end

            bdll_pkg::S_START:
            begin
                case (req_reg.func) inside
                    bdll_pkg::FN_INSERT:
                    begin
                        if (free_cnt == '0)
                        begin
                            res_next   = bdll_pkg::ST_FULL;
                            state_next = bdll_pkg::S_RESULT;
                        end
                        else
                        begin
                            pop        = 1'b1;
                            state_next = bdll_pkg::S_INS;
                        end
                    end
                    bdll_pkg::FN_DEL_KEY, bdll_pkg::FN_DEL_FIRST, bdll_pkg::FN_DUMP:
                    begin
                        if (head_reg >= NIL)
                        begin
                            res_next   = (req_reg.func == bdll_pkg::FN_DUMP)
                                         ? bdll_pkg::ST_EMPTY : bdll_pkg::ST_NONE;
                            state_next = bdll_pkg::S_RESULT;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = head_reg[IW-1:0];
                            cur_next = head_reg;
                            cnt_next = '0;
                            if (req_reg.func == bdll_pkg::FN_DEL_KEY)
                            begin
                                state_next = bdll_pkg::S_DK;
                            end
                            else if (req_reg.func == bdll_pkg::FN_DUMP)
                            begin
                                state_next = bdll_pkg::S_DUMP;
                            end
                            else
                            begin
                                state_next = bdll_pkg::S_UL;
                            end
                        end
                    end
                    bdll_pkg::FN_DEL_LAST:
                    begin
                        if (tail_reg >= NIL)
                        begin
                            res_next   = bdll_pkg::ST_NONE;
                            state_next = bdll_pkg::S_RESULT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = tail_reg[IW-1:0];
                            cur_next   = tail_reg;
                            state_next = bdll_pkg::S_UL;
                        end
                    end
                    default:
                    begin
                        // unused function codes give no result
                        state_next = bdll_pkg::S_IDLE;
                    end
                endcase
            end

            bdll_pkg::S_INS:
            begin
                // new entry goes in front of the old head
                key_we     = 1'b1;
                key_wa     = pop_data;
                next_we    = 1'b1;
                next_wa    = pop_data;
                next_wd    = head_reg;
                prev_we    = 1'b1;
                prev_wa    = pop_data;
                prev_wd    = NIL;
                cur_next   = head_reg;
                head_next  = LW'(pop_data);
                res_next   = bdll_pkg::ST_DONE;
                if (head_reg >= NIL)
                begin
                    tail_next  = LW'(pop_data);
                    state_next = bdll_pkg::S_RESULT;
                end
                else
                begin
                    state_next = bdll_pkg::S_INS2;
                end
            end

            bdll_pkg::S_INS2:
            begin
                // back link of the old head, head already holds the new entry
                prev_we    = 1'b1;
                prev_wa    = cur_reg[IW-1:0];
                prev_wd    = head_reg;
                state_next = bdll_pkg::S_RESULT;
            end

            bdll_pkg::S_DK:
            begin
                if (rd_key == req_reg.key)
                begin
                    do_unlink = 1'b1;
                end
                else if ((rd_next >= NIL) || (cnt_reg == IW'(CAPACITY - 1)))
                begin
                    res_next   = bdll_pkg::ST_NONE;
                    state_next = bdll_pkg::S_RESULT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_next[IW-1:0];
                    cur_next = rd_next;
                    cnt_next = cnt_reg + IW'(1);
                end
            end

            bdll_pkg::S_UL:
            begin
                do_unlink = 1'b1;
            end

            bdll_pkg::S_DUMP:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_word = '{status: bdll_pkg::ST_ELEM, out_key: rd_key,
                                  last_of_run: dump_last};
                    if (dump_last)
                    begin
                        state_next = bdll_pkg::S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = rd_next[IW-1:0];
                        cur_next = rd_next;
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end

            bdll_pkg::S_RESULT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_word  = '{status: res_reg, out_key: '0, last_of_run: 1'b1};
                    state_next = bdll_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bdll_pkg::S_IDLE;
            end
        endcase

        // splice out cur_reg using the links just read, then free it
        if (do_unlink)
        begin
            if (rd_prev < NIL)
            begin
                next_we = 1'b1;
                next_wa = rd_prev[IW-1:0];
                next_wd = rd_next;
            end
            else
            begin
                head_next = rd_next;
            end
            if (rd_next < NIL)
            begin
                prev_we = 1'b1;
                prev_wa = rd_next[IW-1:0];
                prev_wd = rd_prev;
            end
            else
            begin
                tail_next = rd_prev;
            end
            push       = 1'b1;
            push_data  = cur_reg[IW-1:0];
            res_next   = bdll_pkg::ST_DONE;
            state_next = bdll_pkg::S_RESULT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdll_pkg::S_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (emit)
        begin
            out_reg <= emit_word;
        end
        res_reg <= res_next;
        cur_reg <= cur_next;
        cnt_reg <= cnt_next;
    end

    `BDLL_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_reg == bdll_pkg::S_START, "accepted word did not start an operation")
    `BDLL_ASSERT_NOW(a_ends_match, 1'b1, (head_reg >= NIL) == (tail_reg >= NIL), "head and tail disagree on empty list")
    `BDLL_ASSERT_NOW(a_free_bound, 1'b1, free_cnt <= LW'(CAPACITY), "free count above capacity")
    `BDLL_ASSERT_NOW(a_single_last, out_valid_reg && (out_reg.status != bdll_pkg::ST_ELEM), out_reg.last_of_run, "status word without last mark")
    `BDLL_ASSERT_NOW(a_empty_full, (head_reg >= NIL) && (state_reg == bdll_pkg::S_IDLE), free_cnt == LW'(CAPACITY), "empty list with entries in use")

endmodule

`default_nettype wire
